// ----- rtl/core/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/aff2d_pkg.sv -----
package aff2d_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W = 32;
  // step entries need one more bit: negated sine of the most negative value
  localparam int STEP_W = WORD_W + 1;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [STEP_W-1:0] step_val_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    KIND_IDENTITY = 4'd0,
    KIND_TRANSLATE = 4'd1,
    KIND_ROTATE = 4'd2,
    KIND_SCALE = 4'd3,
    KIND_SCALE_X = 4'd4,
    KIND_SCALE_Y = 4'd5,
    KIND_MIRROR_X = 4'd6,
    KIND_MIRROR_Y = 4'd7,
    KIND_POINT = 4'd8
  } kind_t;

  typedef struct packed {
    logic identity;
    logic compose;
    logic point;
  } step_ctl_t;

endpackage

// ----- rtl/core/aff2d_cmd_if.sv -----
interface aff2d_cmd_if;
  logic valid;
  logic ready;
  logic [3:0] kind;
  aff2d_pkg::word_t operand_a;
  aff2d_pkg::word_t operand_b;

  modport source (output valid, output kind, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input kind, input operand_a, input operand_b,
                output ready);
endinterface

// ----- rtl/core/aff2d_res_if.sv -----
interface aff2d_res_if;
  logic valid;
  logic ready;
  aff2d_pkg::word_t out_x;
  aff2d_pkg::word_t out_y;
  logic saturated;

  modport source (output valid, output out_x, output out_y, output saturated,
                  input ready);
  modport sink (input valid, input out_x, input out_y, input saturated,
                output ready);
endinterface

// ----- rtl/core/aff2d_dot.sv -----
// two-term fixed-point dot product plus addend, saturated to one word
module aff2d_dot #(
  parameter int FRAC_BITS = aff2d_pkg::FRAC_BITS_DEF
) (
  input  aff2d_pkg::step_val_t p0,
  input  aff2d_pkg::step_val_t p1,
  input  aff2d_pkg::word_t     q0,
  input  aff2d_pkg::word_t     q1,
  input  aff2d_pkg::step_val_t addend,
  output aff2d_pkg::word_t     res,
  output logic                 sat
);

  localparam int PROD_W = aff2d_pkg::STEP_W + aff2d_pkg::WORD_W;
  localparam int SUM_W = PROD_W + 2;
  localparam logic signed [SUM_W-1:0] MAX_V = SUM_W'(aff2d_pkg::WORD_MAX);
  localparam logic signed [SUM_W-1:0] MIN_V = SUM_W'(aff2d_pkg::WORD_MIN);

  logic signed [PROD_W-1:0] prod0;
  logic signed [PROD_W-1:0] prod1;
  logic signed [PROD_W-1:0] sh0;
  logic signed [PROD_W-1:0] sh1;
  logic signed [SUM_W-1:0]  sum;

  assign prod0 = PROD_W'(p0) * PROD_W'(q0);
  assign prod1 = PROD_W'(p1) * PROD_W'(q1);
  // arithmetic shift floors toward minus infinity
  assign sh0 = prod0 >>> FRAC_BITS;
  assign sh1 = prod1 >>> FRAC_BITS;
  assign sum = SUM_W'(sh0) + SUM_W'(sh1) + SUM_W'(addend);

  always_comb begin
    if (sum > MAX_V) begin
      res = aff2d_pkg::WORD_MAX;
      sat = 1'b1;
    end else if (sum < MIN_V) begin
      res = aff2d_pkg::WORD_MIN;
      sat = 1'b1;
    end else begin
      res = sum[aff2d_pkg::WORD_W-1:0];
      sat = 1'b0;
    end
  end

endmodule

// ----- rtl/core/aff2d_step.sv -----
// command decode: builds the step matrix and the control group
module aff2d_step #(
  parameter int FRAC_BITS = aff2d_pkg::FRAC_BITS_DEF
) (
  input  logic [3:0]           kind,
  input  aff2d_pkg::word_t     a,
  input  aff2d_pkg::word_t     b,
  output aff2d_pkg::step_val_t s [6],
  output aff2d_pkg::step_ctl_t ctl
);

  localparam int ONE_I = 1 << FRAC_BITS;
  localparam aff2d_pkg::step_val_t ONE = aff2d_pkg::step_val_t'(ONE_I);

  aff2d_pkg::step_val_t ax;
  aff2d_pkg::step_val_t bx;

  assign ax = aff2d_pkg::step_val_t'(a);
  assign bx = aff2d_pkg::step_val_t'(b);

  always_comb begin
    s[0] = ONE;
    s[1] = '0;
    s[2] = '0;
    s[3] = '0;
    s[4] = ONE;
    s[5] = '0;
    ctl = '0;
    case (kind)
      aff2d_pkg::KIND_IDENTITY: begin
        ctl.identity = 1'b1;
      end
      aff2d_pkg::KIND_TRANSLATE: begin
        s[2] = ax;
        s[5] = bx;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_ROTATE: begin
        s[0] = ax;
        s[1] = -bx;
        s[3] = bx;
        s[4] = ax;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_SCALE: begin
        s[0] = ax;
        s[4] = ax;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_SCALE_X: begin
        s[0] = ax;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_SCALE_Y: begin
        s[4] = ax;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_MIRROR_X: begin
        s[0] = -ONE;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_MIRROR_Y: begin
        s[4] = -ONE;
        ctl.compose = 1'b1;
      end
      aff2d_pkg::KIND_POINT: begin
        ctl.point = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

endmodule

// ----- rtl/core/affine_2d_transform_engine_core.sv -----
// channel | dir | payload                        | beat carries
// --------+-----+--------------------------------+----------------------------------
// cmd     | in  | kind, operand_a, operand_b     | one command or one point
// res     | out | out_x, out_y, saturated        | one transformed point
//
// one beat per cycle while no point waits on a stalled result; a point comes
// out after its beat passes the input register, then the result register
// the path from input register to matrix and result registers is one pass
// through six parallel 33x32 multiply-add units
// reset sets the matrix to identity and clears the overflow flag
// a stalled result holds its register; the input register still drains
// commands, and only a point waits for the result register to free up
`include "assert_macros.svh"

module affine_2d_transform_engine_core #(
  parameter int FRAC_BITS = aff2d_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  aff2d_cmd_if.sink cmd,
  aff2d_res_if.source res
);

  localparam int ONE_I = 1 << FRAC_BITS;
  localparam aff2d_pkg::word_t ONE_W = aff2d_pkg::word_t'(ONE_I);

  // input register
  logic             s_valid;
  logic [3:0]       s_kind;
  aff2d_pkg::word_t s_a;
  aff2d_pkg::word_t s_b;

  // current transform, row-major a b tx c d ty
  aff2d_pkg::word_t m [6];
  logic             ovf;

  // result register
  logic             o_valid;
  aff2d_pkg::word_t o_x;
  aff2d_pkg::word_t o_y;
  logic             o_sat;

  aff2d_pkg::step_val_t step [6];
  aff2d_pkg::step_ctl_t ctl;
  aff2d_pkg::word_t     dot_res [6];
  logic [5:0]           dot_sat;

  logic out_free;
  logic s_fire;

  assign out_free = !o_valid || res.ready;
  // a point needs the result register, anything else retires at once
  assign s_fire = s_valid && (!ctl.point || out_free);
  assign cmd.ready = !s_valid || s_fire;

  assign res.valid = o_valid;
  assign res.out_x = o_x;
  assign res.out_y = o_y;
  assign res.saturated = o_sat;

  aff2d_step #(.FRAC_BITS(FRAC_BITS)) u_step (
    .kind(s_kind),
    .a   (s_a),
    .b   (s_b),
    .s   (step),
    .ctl (ctl)
  );

  // unit r*3+c makes entry (r, c) of step * current; the last column units
  // double as the point units, x on row 0 and y on row 1
  for (genvar i = 0; i < 6; i++) begin : g_dot
    localparam int R = i / 3;
    localparam int C = i % 3;
    aff2d_pkg::step_val_t p0;
    aff2d_pkg::step_val_t p1;
    aff2d_pkg::word_t     q0;
    aff2d_pkg::word_t     q1;
    aff2d_pkg::step_val_t addend;

    always_comb begin
      p0 = step[R*3];
      p1 = step[R*3+1];
      q0 = m[C];
      q1 = m[3+C];
      addend = (C == 2) ? step[R*3+2] : '0;
      if (C == 2 && ctl.point) begin
        p0 = aff2d_pkg::step_val_t'(m[R*3]);
        p1 = aff2d_pkg::step_val_t'(m[R*3+1]);
        q0 = s_a;
        q1 = s_b;
        addend = aff2d_pkg::step_val_t'(m[R*3+2]);
      end
    end

    aff2d_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
      .p0    (p0),
      .p1    (p1),
      .q0    (q0),
      .q1    (q1),
      .addend(addend),
      .res   (dot_res[i]),
      .sat   (dot_sat[i])
    );
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (cmd.ready) begin
      s_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      s_kind <= cmd.kind;
      s_a <= cmd.operand_a;
      s_b <= cmd.operand_b;
    end
  end

  // matrix and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m[0] <= ONE_W;
      m[1] <= '0;
      m[2] <= '0;
      m[3] <= '0;
      m[4] <= ONE_W;
      m[5] <= '0;
      ovf <= 1'b0;
    end else if (s_fire) begin
      if (ctl.identity) begin
        m[0] <= ONE_W;
        m[1] <= '0;
        m[2] <= '0;
        m[3] <= '0;
        m[4] <= ONE_W;
        m[5] <= '0;
      end else if (ctl.compose) begin
        for (int k = 0; k < 6; k++) begin
          m[k] <= dot_res[k];
        end
        ovf <= ovf || (|dot_sat);
      end else if (ctl.point) begin
        // flag reported with this point, then starts over
        ovf <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_fire && ctl.point) begin
      o_valid <= 1'b1;
    end else if (res.ready) begin
      o_valid <= 1'b0;
    end
    if (s_fire && ctl.point) begin
      o_x <= dot_res[2];
      o_y <= dot_res[5];
      o_sat <= ovf || dot_sat[2] || dot_sat[5];
    end
  end

  // identity command restores the diagonal
  `ASSERT_NEXT(a_identity, clk, rst, s_fire && ctl.identity,
               m[0] == ONE_W && m[4] == ONE_W && m[2] == '0 && m[5] == '0)
  // a taken point always clears the flag
  `ASSERT_NEXT(a_point_clears, clk, rst, s_fire && ctl.point, !ovf && o_valid)
  // flag only rises from a composition
  `ASSERT_IMPL(a_ovf_source, clk, rst, $rose(ovf), $past(s_fire && ctl.compose))
  // points and unused codes leave the matrix alone
  `ASSERT_NEXT(a_matrix_hold, clk, rst, !(s_fire && (ctl.compose || ctl.identity)),
               $stable(m[0]) && $stable(m[2]) && $stable(m[4]) && $stable(m[5]))
  // a point never retires over an untaken result
  `ASSERT_IMPL(a_no_overwrite, clk, rst, s_fire && ctl.point, out_free)

endmodule

// ----- bench/affine_2d_transform_engine_core_tb.sv -----
module affine_2d_transform_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef aff2d_pkg::word_t word_t;

  // fixed point format of the block under test
  localparam int FRAC = aff2d_pkg::FRAC_BITS_DEF;
  localparam longint ONE_Q = longint'(1) << FRAC;

  // kind codes that the block ignores
  localparam logic [3:0] KIND_UNUSED_LO = 4'd9;
  localparam logic [3:0] KIND_UNUSED_HI = 4'd15;

  // random part: beats that the block acts on, and the beats per idling segment
  localparam int RANDOM_BEATS = 1630;
  localparam int SEG_BEATS = 110;
  localparam int PRESSURE_CYCLES = 200;
  // cycles with no beat on either channel before the run is called hung
  localparam int HANG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_PRINTS = 40;

  typedef enum int {
    PH_NONE = 0,
    PH_SEND = 1,
    PH_RECV = 2,
    PH_BOTH = 3,
    PH_PRESSURE = 4
  } idle_phase_t;

  typedef struct {
    logic [3:0] kind;
    word_t a;
    word_t b;
  } cmd_beat_t;

  typedef struct {
    word_t x;
    word_t y;
    bit sat;
  } point_beat_t;

  // running copy of the transform; predicts every point beat
  class affine_board;
    word_t mat[6];
    bit overflow_seen;
    point_beat_t expected_points[$];
    int errors;

    function new();
      set_identity();
      overflow_seen = 0;
      errors = 0;
    endfunction

    function void set_identity();
      foreach (mat[i]) mat[i] = '0;
      mat[0] = word_t'(ONE_Q);
      mat[4] = word_t'(ONE_Q);
    endfunction

    // product truncated toward minus infinity
    function longint fixmul(longint p, longint q);
      return (p * q) >>> FRAC;
    endfunction

    function word_t clamp(longint v, inout bit flag);
      if (v > longint'(aff2d_pkg::WORD_MAX)) begin
        flag = 1;
        return aff2d_pkg::WORD_MAX;
      end
      if (v < longint'(aff2d_pkg::WORD_MIN)) begin
        flag = 1;
        return aff2d_pkg::WORD_MIN;
      end
      return word_t'(v);
    endfunction

    // new matrix = step * current
    function void compose(longint s[6]);
      word_t nw[6];
      bit f;
      f = 0;
      for (int r = 0; r < 2; r++) begin
        nw[3*r] = clamp(fixmul(s[3*r], mat[0]) + fixmul(s[3*r+1], mat[3]), f);
        nw[3*r+1] = clamp(fixmul(s[3*r], mat[1]) + fixmul(s[3*r+1], mat[4]), f);
        nw[3*r+2] = clamp(fixmul(s[3*r], mat[2]) + fixmul(s[3*r+1], mat[5])
                          + s[3*r+2], f);
      end
      mat = nw;
      if (f) overflow_seen = 1;
    endfunction

    function void note_command(logic [3:0] kind, word_t a, word_t b);
      longint s[6];
      point_beat_t p;
      bit f;
      s = '{ONE_Q, 0, 0, 0, ONE_Q, 0};
      case (kind)
        aff2d_pkg::KIND_IDENTITY: begin
          set_identity();
          return;
        end
        aff2d_pkg::KIND_TRANSLATE: begin
          s[2] = a;
          s[5] = b;
        end
        aff2d_pkg::KIND_ROTATE: begin
          s[0] = a;
          s[1] = -longint'(b);
          s[3] = b;
          s[4] = a;
        end
        aff2d_pkg::KIND_SCALE: begin
          s[0] = a;
          s[4] = a;
        end
        aff2d_pkg::KIND_SCALE_X: s[0] = a;
        aff2d_pkg::KIND_SCALE_Y: s[4] = a;
        aff2d_pkg::KIND_MIRROR_X: s[0] = -ONE_Q;
        aff2d_pkg::KIND_MIRROR_Y: s[4] = -ONE_Q;
        aff2d_pkg::KIND_POINT: begin
          f = 0;
          p.x = clamp(fixmul(mat[0], a) + fixmul(mat[1], b) + mat[2], f);
          p.y = clamp(fixmul(mat[3], a) + fixmul(mat[4], b) + mat[5], f);
          p.sat = overflow_seen || f;
          expected_points.push_back(p);
          overflow_seen = 0;
          return;
        end
        default: return;
      endcase
      compose(s);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_point(word_t x, word_t y, logic sat);
      point_beat_t p;
      if (expected_points.size() == 0) begin
        report($sformatf("point beat x=%0d y=%0d with none expected", x, y));
        return;
      end
      p = expected_points.pop_front();
      if (x !== p.x) report($sformatf("out_x %0d, expected %0d", x, p.x));
      if (y !== p.y) report($sformatf("out_y %0d, expected %0d", y, p.y));
      if (sat !== p.sat) report($sformatf("saturated %b, expected %b", sat, p.sat));
    endtask

    task check_drained();
      if (expected_points.size() != 0)
        report($sformatf("%0d point beats never came out", expected_points.size()));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  aff2d_cmd_if cmd();
  aff2d_res_if res();

  affine_2d_transform_engine_core #(.FRAC_BITS(FRAC)) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  affine_board board = new();
  cmd_beat_t stim[$];
  int n_directed;

  // idling mode, registered by the sender so the receiver reads it race free
  idle_phase_t phase = PH_NONE;
  int segment = -1;
  int hang_count = 0;

  function automatic void add(logic [3:0] kind, word_t a, word_t b);
    cmd_beat_t c;
    c.kind = kind;
    c.a = a;
    c.b = b;
    stim.push_back(c);
  endfunction

  // mostly values in a sensible band around zero, some corners and raw words
  function automatic word_t pick_word(int span);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 8) begin
      case ($urandom_range(6))
        0: return aff2d_pkg::WORD_MIN;
        1: return aff2d_pkg::WORD_MAX;
        2: return word_t'(ONE_Q);
        3: return word_t'(-ONE_Q);
        4: return word_t'(-1);
        5: return word_t'(1);
        default: return '0;
      endcase
    end
    if (r < 25) return word_t'($urandom);
    return word_t'(int'($urandom_range(2 * span)) - span);
  endfunction

  function automatic idle_phase_t phase_of(int idx);
    if (idx < n_directed) return PH_NONE;
    return idle_phase_t'(((idx - n_directed) / SEG_BEATS) % 5);
  endfunction

  task automatic build_stimulus();
    int counted;
    int unsigned pick;
    logic [3:0] kind;
    // identity matrix: plain point, and extremes that pass through unchanged
    add(aff2d_pkg::KIND_POINT, word_t'(ONE_Q), word_t'(-ONE_Q));
    add(aff2d_pkg::KIND_POINT, aff2d_pkg::WORD_MAX, aff2d_pkg::WORD_MIN);
    // huge translation: first point saturates, the next one shows the flag cleared
    add(aff2d_pkg::KIND_TRANSLATE, aff2d_pkg::WORD_MAX, aff2d_pkg::WORD_MIN);
    add(aff2d_pkg::KIND_POINT, aff2d_pkg::WORD_MAX, aff2d_pkg::WORD_MAX);
    add(aff2d_pkg::KIND_POINT, '0, '0);
    add(aff2d_pkg::KIND_IDENTITY, word_t'($urandom), word_t'($urandom));
    // scale by the most negative value, then negate it with a mirror
    add(aff2d_pkg::KIND_SCALE, aff2d_pkg::WORD_MIN, word_t'($urandom));
    add(aff2d_pkg::KIND_MIRROR_X, word_t'($urandom), word_t'($urandom));
    // identity keeps the overflow flag until the next point
    add(aff2d_pkg::KIND_IDENTITY, '0, '0);
    add(aff2d_pkg::KIND_POINT, word_t'(ONE_Q), word_t'(ONE_Q));
    // rotate with the most negative sine: negated sine needs the extra bit
    add(aff2d_pkg::KIND_ROTATE, '0, aff2d_pkg::WORD_MIN);
    add(aff2d_pkg::KIND_POINT, word_t'(ONE_Q), word_t'(-ONE_Q));
    add(aff2d_pkg::KIND_IDENTITY, '0, '0);
    add(aff2d_pkg::KIND_SCALE_X, word_t'(2 * ONE_Q), '0);
    add(aff2d_pkg::KIND_SCALE_Y, word_t'(-ONE_Q / 2), '0);
    add(aff2d_pkg::KIND_MIRROR_Y, '0, '0);
    add(aff2d_pkg::KIND_ROTATE, word_t'(56756), word_t'(32768));
    add(aff2d_pkg::KIND_TRANSLATE, word_t'(3 * ONE_Q), word_t'(-7 * ONE_Q));
    add(aff2d_pkg::KIND_POINT, word_t'(5 * ONE_Q + 123), word_t'(-2 * ONE_Q - 7));
    // small negatives exercise truncation toward minus infinity
    add(aff2d_pkg::KIND_POINT, word_t'(-1), word_t'(-3));
    // unused kinds leave the matrix alone
    add(KIND_UNUSED_LO, aff2d_pkg::WORD_MAX, aff2d_pkg::WORD_MIN);
    add(KIND_UNUSED_HI, word_t'($urandom), word_t'($urandom));
    add(aff2d_pkg::KIND_POINT, word_t'(ONE_Q), '0);
    add(aff2d_pkg::KIND_IDENTITY, '0, '0);
    n_directed = stim.size();

    counted = 0;
    while (counted < RANDOM_BEATS) begin
      pick = $urandom_range(99);
      if (pick < 4) kind = 4'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      else if (pick < 10) kind = aff2d_pkg::KIND_IDENTITY;
      else if (pick < 50) kind = aff2d_pkg::KIND_POINT;
      else kind = 4'($urandom_range(aff2d_pkg::KIND_MIRROR_Y, aff2d_pkg::KIND_TRANSLATE));
      case (kind)
        aff2d_pkg::KIND_TRANSLATE:
          add(kind, pick_word(64 * ONE_Q), pick_word(64 * ONE_Q));
        aff2d_pkg::KIND_ROTATE: add(kind, pick_word(ONE_Q), pick_word(ONE_Q));
        aff2d_pkg::KIND_SCALE, aff2d_pkg::KIND_SCALE_X, aff2d_pkg::KIND_SCALE_Y:
          add(kind, pick_word(2 * ONE_Q), word_t'($urandom));
        aff2d_pkg::KIND_POINT:
          add(kind, pick_word(256 * ONE_Q), pick_word(256 * ONE_Q));
        default: add(kind, word_t'($urandom), word_t'($urandom));
      endcase
      // ignored kinds do not count toward the random part
      if (kind < KIND_UNUSED_LO) counted++;
    end
  endtask

  // offers the command beats in order; a held offer never changes
  task automatic send_cmds();
    int idx;
    int gap;
    idle_phase_t ph;
    idx = 0;
    while (idx < stim.size()) begin
      @(posedge clk);
      if (cmd.valid && cmd.ready) idx++;
      ph = phase_of(idx);
      gap = (ph == PH_SEND) ? 48 : (ph == PH_BOTH) ? 12 : 0;
      if (!cmd.valid || cmd.ready) begin
        if (idx < stim.size() && $urandom_range(99) >= gap) begin
          cmd.valid <= 1'b1;
          cmd.kind <= stim[idx].kind;
          cmd.operand_a <= stim[idx].a;
          cmd.operand_b <= stim[idx].b;
        end else begin
          cmd.valid <= 1'b0;
        end
      end
      phase <= ph;
      segment <= (idx < n_directed) ? -1 : (idx - n_directed) / SEG_BEATS;
    end
  endtask

  // result side: random stalls, and one long hold per pressure segment
  task automatic take_results();
    int last_held;
    int stall;
    last_held = -1;
    forever begin
      @(posedge clk);
      if (phase == PH_PRESSURE && segment != last_held) begin
        // long hold while the sender keeps offering, so the input backs up
        last_held = segment;
        res.ready <= 1'b0;
        repeat (PRESSURE_CYCLES) @(posedge clk);
      end else begin
        stall = (phase == PH_RECV) ? 48 : (phase == PH_BOTH) ? 12 : 0;
        res.ready <= ($urandom_range(99) >= stall);
      end
    end
  endtask

  // beats are sampled before this edge's updates land; results checked first
  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) board.check_point(res.out_x, res.out_y, res.saturated);
      if (cmd.valid && cmd.ready) board.note_command(cmd.kind, cmd.operand_a, cmd.operand_b);
    end
  end

  // hang detection: cycles in a row with no beat on either channel
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      hang_count <= 0;
    end else begin
      hang_count <= hang_count + 1;
      if (hang_count >= HANG_LIMIT) begin
        $display("[affine_2d_transform_engine_core] ERROR");
        $finish;
      end
    end
  end

  initial begin
    cmd.valid = 1'b0;
    cmd.kind = aff2d_pkg::KIND_IDENTITY;
    cmd.operand_a = '0;
    cmd.operand_b = '0;
    res.ready = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    fork
      take_results();
    join_none
    send_cmds();
    // every command is in; wait out the points still in flight
    while (board.expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) begin
      $display("[affine_2d_transform_engine_core] OK");
    end else begin
      $display("[affine_2d_transform_engine_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- affine_2d_transform_engine_core.f -----
+incdir+rtl/core
rtl/core/aff2d_pkg.sv
rtl/core/aff2d_cmd_if.sv
rtl/core/aff2d_res_if.sv
rtl/core/aff2d_dot.sv
rtl/core/aff2d_step.sv
rtl/core/affine_2d_transform_engine_core.sv
bench/affine_2d_transform_engine_core_tb.sv
